@@ hdl/esczw_pkg.sv @@
// ----------------------------------------------------------------------------
// esczw_pkg
// Byte codes, configuration indexes and character class helpers for the
// escape sequence zero-width marker.
// ----------------------------------------------------------------------------
package esczw_pkg;

    typedef logic [7:0] t_byte;
    typedef logic       t_cfg_idx;

    localparam t_cfg_idx CFG_START_MARKER = 1'b0;
    localparam t_cfg_idx CFG_END_MARKER   = 1'b1;

    localparam t_byte START_MARKER_RST = 8'h01;
    localparam t_byte END_MARKER_RST   = 8'h02;

    localparam t_byte CH_BEL  = 8'h07;
    localparam t_byte CH_TAB  = 8'h09;
    localparam t_byte CH_LF   = 8'h0A;
    localparam t_byte CH_CR   = 8'h0D;
    localparam t_byte CH_ESC  = 8'h1B;
    localparam t_byte CH_DEL  = 8'h7F;
    localparam t_byte CH_LBRK = 8'h5B;
    localparam t_byte CH_RBRK = 8'h5D;
    localparam t_byte CH_BSL  = 8'h5C;
    localparam t_byte CH_DCS  = 8'h50;
    localparam t_byte CH_SOS  = 8'h58;
    localparam t_byte CH_PM   = 8'h5E;
    localparam t_byte CH_APC  = 8'h5F;

    function automatic logic is_letter(input t_byte c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_ctrl(input t_byte c);
        return (c <= 8'h1F) || (c == CH_DEL);
    endfunction

    function automatic logic is_kept_ctrl(input t_byte c);
        return (c == CH_BEL) || (c == CH_ESC) || (c == CH_LF) || (c == CH_CR) ||
               (c == CH_TAB);
    endfunction

    function automatic logic is_string_intro(input t_byte c);
        return (c == CH_DCS) || (c == CH_SOS) || (c == CH_PM) || (c == CH_APC);
    endfunction

endpackage

@@ hdl/escape_sequence_zero_width_marker_top.sv @@
// ----------------------------------------------------------------------------
// escape_sequence_zero_width_marker_top
// Brackets terminal escape sequences and stray control bytes of a prompt
// stream with start and end marker bytes.
// ----------------------------------------------------------------------------
// the first result of a byte appears in the cycle after its input transfer
// throughput: one byte per cycle while each byte yields one result and the
//   receiver is ready; a byte that yields 1 to 3 results holds the output
//   port while the three-entry result buffer drains one entry per ready cycle
// reset: synchronous active low; clears parser flags, empties the result buffer,
//   markers return to 0x01 (start) and 0x02 (end)
module escape_sequence_zero_width_marker_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // slave side: tdata = char_byte[7:0]; tlast = last_of_string
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  esczw_pkg::t_byte          i_s_tdata,
    input  logic                      i_s_tlast,
    // master side: tdata = out_byte[7:0]; tlast = last_of_run;
    // tuser = string_done
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output esczw_pkg::t_byte          o_m_tdata,
    output logic                      o_m_tlast,
    output logic                      o_m_tuser,
    // configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  esczw_pkg::t_cfg_idx       i_cfg_addr,
    input  esczw_pkg::t_byte          i_cfg_data
);
    import esczw_pkg::*;

    t_byte       r_start;
    t_byte       r_end;

    logic        r_ae, r_cs, r_os, r_sc, r_te, r_ro;
    logic        n_ae, n_cs, n_os, n_sc, n_te, n_ro;

    t_byte       r_buf [0:2];
    t_byte       n_buf [0:2];
    logic [1:0]  r_rem;
    logic [1:0]  n_cnt;
    logic        r_str;

    logic        done;
    logic        s_xfer;
    logic        m_xfer;
    t_byte       c;

    assign c           = i_s_tdata;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = (r_rem != 2'd0);
    assign o_m_tdata   = r_buf[0];
    assign o_m_tlast   = (r_rem == 2'd1);
    assign o_m_tuser   = (r_rem == 2'd1) && r_str;
    assign m_xfer      = o_m_tvalid && i_m_tready;
    // take a new byte once the buffer empties in this cycle
    assign o_s_tready  = (r_rem == 2'd0) || ((r_rem == 2'd1) && i_m_tready);
    assign s_xfer      = i_s_tvalid && o_s_tready;

    always_comb begin
        n_ae  = r_ae;
        n_cs  = r_cs;
        n_os  = r_os;
        n_sc  = r_sc;
        n_te  = r_te;
        n_ro  = r_ro;
        n_buf = '{default: '0};
        n_cnt = 2'd0;
        done  = 1'b0;

        if (c == CH_ESC) begin
            n_ae = 1'b1;
            if (!n_ro) begin
                n_buf[n_cnt] = r_start;
                n_cnt = n_cnt + 2'd1;
            end
            n_ro = 1'b1;
        end
        if (n_ae && (c == CH_LBRK)) begin
            n_ae = 1'b0;
            n_cs = 1'b1;
        end
        if (n_ae && (c == CH_RBRK)) begin
            n_ae = 1'b0;
            n_os = 1'b1;
            n_sc = 1'b1;
        end
        if (n_ae && is_string_intro(c)) begin
            n_ae = 1'b0;
            n_sc = 1'b1;
        end
        // esc + letter closes with an end marker but leaves the run open
        if (n_ae && is_letter(c)) begin
            n_buf[n_cnt] = c;
            n_cnt = n_cnt + 2'd1;
            n_buf[n_cnt] = r_end;
            n_cnt = n_cnt + 2'd1;
            n_ae = 1'b0;
            done = 1'b1;
        end
        if (!done && is_ctrl(c) && !is_kept_ctrl(c)) begin
            if (!n_ro) begin
                n_buf[n_cnt] = r_start;
                n_cnt = n_cnt + 2'd1;
            end
            n_ro = 1'b1;
        end
        if (!done && n_cs && is_letter(c)) begin
            n_buf[n_cnt] = c;
            n_cnt = n_cnt + 2'd1;
            n_buf[n_cnt] = r_end;
            n_cnt = n_cnt + 2'd1;
            n_cs = 1'b0;
            n_ro = 1'b0;
            done = 1'b1;
        end
        if (!done && n_os && (c == CH_BEL)) begin
            n_buf[n_cnt] = c;
            n_cnt = n_cnt + 2'd1;
            n_buf[n_cnt] = r_end;
            n_cnt = n_cnt + 2'd1;
            n_os = 1'b0;
            n_sc = 1'b0;
            n_ro = 1'b0;
            done = 1'b1;
        end
        // string terminator: esc flag deliberately kept after the backslash
        if (!done && n_te) begin
            if (c == CH_BSL) begin
                n_buf[n_cnt] = c;
                n_cnt = n_cnt + 2'd1;
                n_buf[n_cnt] = r_end;
                n_cnt = n_cnt + 2'd1;
                n_sc = 1'b0;
                n_ro = 1'b0;
                done = 1'b1;
            end else begin
                n_te = 1'b0;
            end
        end
        if (!done) begin
            if (n_sc && (c == CH_ESC)) begin
                n_te = 1'b1;
            end
            n_buf[n_cnt] = c;
            n_cnt = n_cnt + 2'd1;
        end
        if (i_s_tlast) begin
            if (n_ro) begin
                n_buf[n_cnt] = r_end;
                n_cnt = n_cnt + 2'd1;
            end
            n_ae = 1'b0;
            n_cs = 1'b0;
            n_os = 1'b0;
            n_sc = 1'b0;
            n_te = 1'b0;
            n_ro = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_MARKER_RST;
            r_end   <= END_MARKER_RST;
            r_ae    <= 1'b0;
            r_cs    <= 1'b0;
            r_os    <= 1'b0;
            r_sc    <= 1'b0;
            r_te    <= 1'b0;
            r_ro    <= 1'b0;
            r_rem   <= 2'd0;
            r_str   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_addr)
                    CFG_START_MARKER: r_start <= i_cfg_data;
                    CFG_END_MARKER:   r_end   <= i_cfg_data;
                    default:          r_start <= r_start;
                endcase
            end
            if (s_xfer) begin
                r_ae  <= n_ae;
                r_cs  <= n_cs;
                r_os  <= n_os;
                r_sc  <= n_sc;
                r_te  <= n_te;
                r_ro  <= n_ro;
                r_rem <= n_cnt;
                r_str <= i_s_tlast;
            end else if (m_xfer) begin
                r_rem <= r_rem - 2'd1;
            end
        end
    end

    // result buffer payload, shifts toward the head on each output transfer
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_buf <= n_buf;
        end else if (m_xfer) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

endmodule

@@ hdl/esczw_checker.sv @@
// ----------------------------------------------------------------------------
// esczw_checker
// Port-level checks for the escape sequence zero-width marker.
// ----------------------------------------------------------------------------
module esczw_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      o_s_tready,
    input  logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    input  esczw_pkg::t_byte          o_m_tdata,
    input  logic                      o_m_tlast,
    input  logic                      o_m_tuser
);

    // string done only on the final result of a byte
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("string done without last of run");

    // a new byte is taken only when the pending results finish now
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |->
            (!o_m_tvalid || (o_m_tlast && i_m_tready)))
        else $error("input transfer while results still pending");

    // every accepted byte produces at least one result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("no result after input transfer");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled result changed");

endmodule

bind escape_sequence_zero_width_marker_top esczw_checker u_esczw_checker (.*);

@@ tb/tb_escape_sequence_zero_width_marker_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_escape_sequence_zero_width_marker_top
// Streams prompt bytes into the marker block and checks every output transfer
// against a behavioral predictor of the escape parser. Directed prompts come
// first, then random prompts built mostly from well-formed escape sequences,
// across several marker settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_escape_sequence_zero_width_marker_top;
    import esczw_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_PRINTS   = 100;

    typedef struct packed {
        t_byte ch;
        logic  lst;
    } t_prompt_item;

    typedef struct packed {
        t_byte b;
        logic  run_end;
        logic  str_end;
    } t_marked_byte;

    typedef enum int {
        SEG_TEXT,
        SEG_CSI,
        SEG_OSC_BEL,
        SEG_OSC_ST,
        SEG_STR_CMD,
        SEG_ESC_LETTER,
        SEG_STRAY_CTL,
        SEG_NOISE,
        SEG_BROKEN
    } t_seg_kind;

    logic     i_clk;
    logic     i_rst_n     = 1'b0;
    logic     i_s_tvalid  = 1'b0;
    logic     o_s_tready;
    t_byte    i_s_tdata   = '0;
    logic     i_s_tlast   = 1'b0;
    logic     o_m_tvalid;
    logic     i_m_tready  = 1'b0;
    t_byte    o_m_tdata;
    logic     o_m_tlast;
    logic     o_m_tuser;
    logic     i_cfg_valid = 1'b0;
    logic     o_cfg_ready;
    t_cfg_idx i_cfg_addr  = CFG_START_MARKER;
    t_byte    i_cfg_data  = '0;

    escape_sequence_zero_width_marker_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),    // char_byte[7:0]
        .i_s_tlast  (i_s_tlast),    // last_of_string
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),    // out_byte[7:0]
        .o_m_tlast  (o_m_tlast),    // last_of_run
        .o_m_tuser  (o_m_tuser),    // string_done
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    // parser state mirrored by the predictor
    t_byte start_mk    = START_MARKER_RST;
    t_byte end_mk      = END_MARKER_RST;
    logic  esc_pending = 1'b0;
    logic  in_csi      = 1'b0;
    logic  in_osc      = 1'b0;
    logic  in_strcmd   = 1'b0;
    logic  st_esc_seen = 1'b0;
    logic  zw_open     = 1'b0;

    t_prompt_item pend_q[$];
    t_marked_byte marked_q[$];
    t_byte        frag_q[$];
    t_prompt_item nxt_item;
    t_marked_byte want;

    int cyc        = 0;
    int errors     = 0;
    int burst_left = 4;
    int gap_left   = 0;
    int stall_mode = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic alpha_byte(input t_byte c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic ctl_byte(input t_byte c);
        return (c < 8'h20) || (c == CH_DEL);
    endfunction

    // control bytes exempt from the stray-control rule; of these only escape opens a run
    function automatic logic passthru_ctl(input t_byte c);
        return c == CH_BEL || c == CH_ESC || c == CH_LF || c == CH_CR || c == CH_TAB;
    endfunction

    function automatic logic str_intro_byte(input t_byte c);
        return c == CH_DCS || c == CH_SOS || c == CH_PM || c == CH_APC;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("cycle %0d: %s: got 0x%0h, expected 0x%0h", cyc, what, got, exp_val);
    endtask

    // works out the output bytes of one accepted prompt byte
    task automatic predict_marked_bytes(input t_byte c, input logic lst);
        t_byte ob[4];
        int    n;
        logic  done;
        n    = 0;
        done = 1'b0;
        if (c == CH_ESC) begin
            esc_pending = 1'b1;
            if (!zw_open) begin
                ob[n] = start_mk;
                n++;
            end
            zw_open = 1'b1;
        end
        if (esc_pending && c == CH_LBRK) begin
            esc_pending = 1'b0;
            in_csi      = 1'b1;
        end
        if (esc_pending && c == CH_RBRK) begin
            esc_pending = 1'b0;
            in_osc      = 1'b1;
            in_strcmd   = 1'b1;
        end
        if (esc_pending && str_intro_byte(c)) begin
            esc_pending = 1'b0;
            in_strcmd   = 1'b1;
        end
        // two-byte escape: end marker goes out but the run stays open
        if (esc_pending && alpha_byte(c)) begin
            ob[n]     = c;
            ob[n + 1] = end_mk;
            n += 2;
            esc_pending = 1'b0;
            done        = 1'b1;
        end
        if (!done && ctl_byte(c) && !passthru_ctl(c)) begin
            if (!zw_open) begin
                ob[n] = start_mk;
                n++;
            end
            zw_open = 1'b1;
        end
        if (!done && in_csi && alpha_byte(c)) begin
            ob[n]     = c;
            ob[n + 1] = end_mk;
            n += 2;
            in_csi  = 1'b0;
            zw_open = 1'b0;
            done    = 1'b1;
        end
        if (!done && in_osc && c == CH_BEL) begin
            ob[n]     = c;
            ob[n + 1] = end_mk;
            n += 2;
            in_osc    = 1'b0;
            in_strcmd = 1'b0;
            zw_open   = 1'b0;
            done      = 1'b1;
        end
        // string terminator: the escape flag is left set after the backslash
        if (!done && st_esc_seen) begin
            if (c == CH_BSL) begin
                ob[n]     = c;
                ob[n + 1] = end_mk;
                n += 2;
                in_strcmd = 1'b0;
                zw_open   = 1'b0;
                done      = 1'b1;
            end else begin
                st_esc_seen = 1'b0;
            end
        end
        if (!done) begin
            if (in_strcmd && c == CH_ESC)
                st_esc_seen = 1'b1;
            ob[n] = c;
            n++;
        end
        if (lst) begin
            if (zw_open) begin
                ob[n] = end_mk;
                n++;
            end
            esc_pending = 1'b0;
            in_csi      = 1'b0;
            in_osc      = 1'b0;
            in_strcmd   = 1'b0;
            st_esc_seen = 1'b0;
            zw_open     = 1'b0;
        end
        for (int k = 0; k < n; k++)
            marked_q.push_back('{b: ob[k], run_end: (k == n - 1), str_end: (k == n - 1) && lst});
    endtask

    // prompt sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                predict_marked_bytes(i_s_tdata, i_s_tlast);
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    nxt_item = pend_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= nxt_item.ch;
                    i_s_tlast  <= nxt_item.lst;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output checker and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (marked_q.size() == 0) begin
                report_mismatch("output transfer with nothing expected", o_m_tdata, 0);
            end else begin
                want = marked_q.pop_front();
                if (o_m_tdata !== want.b)
                    report_mismatch("out_byte", o_m_tdata, want.b);
                if (o_m_tlast !== want.run_end)
                    report_mismatch("last_of_run", o_m_tlast, want.run_end);
                if (o_m_tuser !== want.str_end)
                    report_mismatch("string_done", o_m_tuser, want.str_end);
            end
        end
        if (cyc % 64 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= ($urandom_range(0, 1) == 1);
            default: i_m_tready <= (cyc % 4 == 0);
        endcase
    end

    task automatic write_marker_reg(input t_cfg_idx idx, input t_byte val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_START_MARKER)
            start_mk = val;
        else
            end_mk = val;
    endtask

    task automatic wait_idle();
        while (pend_q.size() != 0 || i_s_tvalid || marked_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic add_item(input t_byte c, input logic lst);
        pend_q.push_back('{ch: c, lst: lst});
    endtask

    function automatic t_byte rand_letter();
        if ($urandom_range(0, 1))
            return t_byte'(8'h41 + $urandom_range(0, 25));
        return t_byte'(8'h61 + $urandom_range(0, 25));
    endfunction

    function automatic t_seg_kind pick_segment();
        int r;
        r = $urandom_range(0, 99);
        if (r < 16) return SEG_TEXT;
        if (r < 32) return SEG_CSI;
        if (r < 42) return SEG_OSC_BEL;
        if (r < 52) return SEG_OSC_ST;
        if (r < 64) return SEG_STR_CMD;
        if (r < 74) return SEG_ESC_LETTER;
        if (r < 84) return SEG_STRAY_CTL;
        if (r < 92) return SEG_NOISE;
        return SEG_BROKEN;
    endfunction

    task automatic add_text(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) frag_q.push_back(t_byte'($urandom_range(8'h20, 8'h7E)));
    endtask

    task automatic add_segment();
        int        n;
        t_seg_kind kind;
        kind = pick_segment();
        case (kind)
            SEG_TEXT: begin
                add_text(1, 4);
            end
            SEG_CSI: begin
                frag_q.push_back(CH_ESC);
                frag_q.push_back(CH_LBRK);
                n = $urandom_range(0, 3);
                repeat (n) frag_q.push_back(t_byte'($urandom_range(8'h30, 8'h3B)));
                frag_q.push_back(rand_letter());
            end
            SEG_OSC_BEL, SEG_OSC_ST: begin
                frag_q.push_back(CH_ESC);
                frag_q.push_back(CH_RBRK);
                add_text(0, 4);
                if (kind == SEG_OSC_BEL) begin
                    frag_q.push_back(CH_BEL);
                end else begin
                    frag_q.push_back(CH_ESC);
                    frag_q.push_back(CH_BSL);
                end
            end
            SEG_STR_CMD: begin
                frag_q.push_back(CH_ESC);
                case ($urandom_range(0, 3))
                    0:       frag_q.push_back(CH_DCS);
                    1:       frag_q.push_back(CH_SOS);
                    2:       frag_q.push_back(CH_PM);
                    default: frag_q.push_back(CH_APC);
                endcase
                add_text(0, 4);
                frag_q.push_back(CH_ESC);
                frag_q.push_back(CH_BSL);
            end
            SEG_ESC_LETTER: begin
                frag_q.push_back(CH_ESC);
                frag_q.push_back(rand_letter());
            end
            SEG_STRAY_CTL: begin
                if ($urandom_range(0, 7) == 0)
                    frag_q.push_back(CH_DEL);
                else
                    frag_q.push_back(t_byte'($urandom_range(0, 31)));
            end
            SEG_NOISE: begin
                n = $urandom_range(1, 3);
                repeat (n) frag_q.push_back(t_byte'($urandom_range(0, 255)));
            end
            default: begin
                // escape followed by anything, or an unterminated sequence
                frag_q.push_back(CH_ESC);
                frag_q.push_back(t_byte'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic queue_prompt(output int n_bytes);
        int target;
        target = $urandom_range(1, 10);
        frag_q.delete();
        while (frag_q.size() < target)
            add_segment();
        foreach (frag_q[k])
            add_item(frag_q[k], k == frag_q.size() - 1);
        n_bytes = frag_q.size();
    endtask

    task automatic run_prompt_phase(input t_byte smk, input t_byte emk, input int n_items);
        int added;
        int n;
        added = 0;
        write_marker_reg(CFG_START_MARKER, smk);
        write_marker_reg(CFG_END_MARKER, emk);
        while (added < n_items) begin
            queue_prompt(n);
            added += n;
        end
        wait_idle();
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed prompts with the reset markers
        add_item(8'h00, 1'b0);      // zero byte opens a run
        add_item(8'hFF, 1'b0);
        add_item(CH_ESC, 1'b0);
        add_item(8'h41, 1'b0);      // escape + letter keeps the run open
        add_item(CH_ESC, 1'b0);
        add_item(CH_LBRK, 1'b0);
        add_item(8'h6D, 1'b0);      // csi ends on a letter
        add_item(CH_ESC, 1'b0);
        add_item(CH_RBRK, 1'b0);
        add_item(8'h30, 1'b0);
        add_item(CH_BEL, 1'b0);     // osc ends on bel
        add_item(CH_ESC, 1'b0);
        add_item(CH_DCS, 1'b0);
        add_item(CH_ESC, 1'b0);
        add_item(CH_BSL, 1'b0);     // dcs ends on escape backslash
        add_item(8'h78, 1'b0);
        add_item(CH_ESC, 1'b0);
        add_item(CH_RBRK, 1'b0);
        add_item(CH_ESC, 1'b0);
        add_item(CH_BSL, 1'b0);
        add_item(CH_LF, 1'b0);
        add_item(CH_DEL, 1'b0);
        add_item(8'h7A, 1'b1);      // string end closes the open run
        add_item(CH_ESC, 1'b1);
        add_item(8'h80, 1'b1);
        wait_idle();
        repeat (4) @(posedge i_clk);

        run_prompt_phase(8'h00, 8'hFF, 20);
        run_prompt_phase(8'hFF, 8'h00, 20);
        run_prompt_phase(CH_ESC, CH_BSL, 20);
        run_prompt_phase(t_byte'($urandom_range(0, 255)), t_byte'($urandom_range(0, 255)), 20);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (marked_q.size() != 0)
            report_mismatch("results never received", marked_q.size(), 0);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
